[design/hdtb_pkg.sv]
// Shared types and constants for the canonical Huffman lookup table builder.
`default_nettype none
package hdtb_pkg;

    localparam int unsigned HDR_BYTES = 16;

    typedef enum logic {
        REQ_SPEC = 1'b0,
        REQ_READ = 1'b1
    } t_req_kind;

    typedef struct packed {
        logic        req_type;
        logic        start_req;
        logic [7:0]  data_byte;
        logic [16:0] read_index;
    } t_req;

    typedef struct packed {
        logic [12:0] read_word;
        logic        in_range;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_FILL,
        ST_SEEK
    } t_state;

endpackage
`default_nettype wire

[design/hdtb_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module hdtb_ram #(
    parameter int unsigned WIDTH = 13,
    parameter int unsigned DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[design/huffman_decode_table_builder.sv]
// Canonical Huffman lookup table builder: count/symbol intake, table fill and word readout.
// Count byte: stored when accepted. Read: accepted, result strobed on the next cycle, busy for that cycle.
// Symbol byte: the fill sequencer writes up to 2^(longest-L) copies, one table word per cycle.
// The last count byte and the last symbol of a length add a length search.
// Synchronous active-low reset clears all control state and the counts; the table RAM is
// not cleared: words at or past the fill pointer read as zero.
`default_nettype none
module huffman_decode_table_builder #(
    parameter int unsigned MAX_CODE_LEN = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire hdtb_pkg::t_req  i_req,
    output logic                 o_strobe,
    output hdtb_pkg::t_result    o_result
);

    localparam int unsigned ADDR_W = MAX_CODE_LEN;
    localparam int unsigned PTR_W  = MAX_CODE_LEN + 1;
    localparam int unsigned DEPTH  = 1 << MAX_CODE_LEN;

    hdtb_pkg::t_state r_state, n_state;

    logic [7:0]        r_counts [hdtb_pkg::HDR_BYTES];
    logic [7:0]        n_counts [hdtb_pkg::HDR_BYTES];
    logic [4:0]        r_seen, n_seen;
    logic [4:0]        r_pending, n_pending;
    logic [4:0]        r_longest, n_longest;
    logic [4:0]        r_cur, n_cur;
    logic [7:0]        r_left, n_left;
    logic [PTR_W-1:0]  r_fill, n_fill;
    logic [ADDR_W-1:0] r_reps, n_reps;
    logic [7:0]        r_sym, n_sym;
    logic              r_rd_idx0, n_rd_idx0;
    logic              r_rd_inr, n_rd_inr;
    logic              r_rd_mem, n_rd_mem;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [12:0]       ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [12:0]       ram_q;

    logic              w_accept;
    logic [PTR_W-1:0]  w_limit;
    logic [4:0]        w_eff_seen;
    logic [4:0]        w_eff_pending;
    logic              w_hdr_done;
    logic              w_sym_take;
    logic              w_fill_ok;
    logic              w_fill_done;
    logic [4:0]        w_cur_m1;
    logic [3:0]        w_cur_idx;
    logic              w_seek_more;
    logic [16:0]       w_idx_m1;

    assign busy       = (r_state != hdtb_pkg::ST_IDLE);
    assign w_accept   = start && !busy;
    assign w_limit    = PTR_W'(1) << r_longest;
    assign w_eff_seen = i_req.start_req ? 5'd0 : r_seen;
    assign w_eff_pending = i_req.start_req ? 5'd0 : r_pending;
    assign w_hdr_done = (w_eff_seen == 5'(hdtb_pkg::HDR_BYTES - 1));
    assign w_sym_take = (r_cur <= r_longest) && (r_left != 8'd0);
    assign w_fill_ok  = (r_fill <= w_limit);
    // stop early once past the table end: remaining words would be dropped anyway
    assign w_fill_done = (r_reps == ADDR_W'(1)) || !w_fill_ok;
    assign w_cur_m1   = r_cur - 5'd1;
    assign w_cur_idx  = w_cur_m1[3:0];
    assign w_seek_more = (r_cur <= r_longest) && (r_counts[w_cur_idx] == 8'd0);
    assign w_idx_m1   = i_req.read_index - 17'd1;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hdtb_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_req.req_type == hdtb_pkg::REQ_READ) begin
                        n_state = hdtb_pkg::ST_READ;
                    end else if (w_eff_seen < 5'(hdtb_pkg::HDR_BYTES)) begin
                        if (w_hdr_done) begin
                            n_state = hdtb_pkg::ST_SEEK;
                        end
                    end else if (w_sym_take) begin
                        n_state = hdtb_pkg::ST_FILL;
                    end
                end
            end
            hdtb_pkg::ST_READ: begin
                n_state = hdtb_pkg::ST_IDLE;
            end
            hdtb_pkg::ST_FILL: begin
                if (w_fill_done) begin
                    n_state = (r_left == 8'd1) ? hdtb_pkg::ST_SEEK : hdtb_pkg::ST_IDLE;
                end
            end
            hdtb_pkg::ST_SEEK: begin
                if (!w_seek_more) begin
                    n_state = hdtb_pkg::ST_IDLE;
                end
            end
            default: n_state = hdtb_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        n_counts  = r_counts;
        n_seen    = r_seen;
        n_pending = r_pending;
        n_longest = r_longest;
        n_cur     = r_cur;
        n_left    = r_left;
        n_fill    = r_fill;
        n_reps    = r_reps;
        n_sym     = r_sym;
        n_rd_idx0 = r_rd_idx0;
        n_rd_inr  = r_rd_inr;
        n_rd_mem  = r_rd_mem;
        ram_we    = 1'b0;
        ram_waddr = ADDR_W'(r_fill - PTR_W'(1));
        ram_wdata = {r_cur, r_sym};
        ram_raddr = w_idx_m1[ADDR_W-1:0];
        o_strobe  = (r_state == hdtb_pkg::ST_READ);
        o_result.in_range  = r_rd_inr;
        o_result.read_word = r_rd_mem  ? ram_q :
                             r_rd_idx0 ? 13'(r_longest) : 13'd0;
        case (r_state)
            hdtb_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_req.req_type == hdtb_pkg::REQ_READ) begin
                        n_rd_idx0 = (i_req.read_index == 17'd0);
                        n_rd_inr  = (i_req.read_index <= 17'(w_limit));
                        n_rd_mem  = (i_req.read_index != 17'd0)
                                 && (i_req.read_index <= 17'(w_limit))
                                 && (i_req.read_index < 17'(r_fill));
                    end else begin
                        if (i_req.start_req) begin
                            for (int i = 0; i < hdtb_pkg::HDR_BYTES; i++) begin
                                n_counts[i] = 8'd0;
                            end
                            n_longest = 5'd0;
                            n_cur     = 5'd1;
                            n_left    = 8'd0;
                            n_fill    = PTR_W'(1);
                        end
                        if (w_eff_seen < 5'(hdtb_pkg::HDR_BYTES)) begin
                            n_counts[w_eff_seen[3:0]] = i_req.data_byte;
                            n_seen = w_eff_seen + 5'd1;
                            // latest nonzero count within range sets the longest length
                            if (i_req.data_byte != 8'd0 && w_eff_seen < 5'(MAX_CODE_LEN)) begin
                                n_pending = w_eff_seen + 5'd1;
                            end else begin
                                n_pending = w_eff_pending;
                            end
                            if (w_hdr_done) begin
                                n_longest = n_pending;
                                n_cur     = 5'd1;
                            end
                        end else if (w_sym_take) begin
                            n_sym  = i_req.data_byte;
                            n_reps = ADDR_W'(1) << (r_longest - r_cur);
                        end
                    end
                end
            end
            hdtb_pkg::ST_FILL: begin
                if (w_fill_ok) begin
                    ram_we = 1'b1;
                    n_fill = r_fill + PTR_W'(1);
                end
                n_reps = r_reps - ADDR_W'(1);
                if (w_fill_done) begin
                    n_left = r_left - 8'd1;
                    if (r_left == 8'd1) begin
                        n_cur = r_cur + 5'd1;
                    end
                end
            end
            hdtb_pkg::ST_SEEK: begin
                if (w_seek_more) begin
                    n_cur = r_cur + 5'd1;
                end else begin
                    n_left = (r_cur <= r_longest) ? r_counts[w_cur_idx] : 8'd0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= hdtb_pkg::ST_IDLE;
            for (int i = 0; i < hdtb_pkg::HDR_BYTES; i++) begin
                r_counts[i] <= 8'd0;
            end
            r_seen    <= 5'd0;
            r_pending <= 5'd0;
            r_longest <= 5'd0;
            r_cur     <= 5'd1;
            r_left    <= 8'd0;
            r_fill    <= PTR_W'(1);
        end else begin
            r_state   <= n_state;
            r_counts  <= n_counts;
            r_seen    <= n_seen;
            r_pending <= n_pending;
            r_longest <= n_longest;
            r_cur     <= n_cur;
            r_left    <= n_left;
            r_fill    <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_reps    <= n_reps;
        r_sym     <= n_sym;
        r_rd_idx0 <= n_rd_idx0;
        r_rd_inr  <= n_rd_inr;
        r_rd_mem  <= n_rd_mem;
    end

    hdtb_ram #(
        .WIDTH (13),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    a_read_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.req_type == hdtb_pkg::REQ_READ) |=> o_strobe)
        else $error("read item produced no result");

    a_result_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_accept && i_req.req_type == hdtb_pkg::REQ_READ))
        else $error("result without a read item");

    a_write_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_fill != PTR_W'(0)) && (r_fill <= w_limit))
        else $error("table write outside filled range");

    a_fill_length_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hdtb_pkg::ST_FILL) |-> (r_cur != 5'd0) && (r_cur <= r_longest))
        else $error("fill with unused code length");

endmodule
`default_nettype wire

[bench/hdtb_lookup_checker.sv]
// Lookup table checker: rebuilds the decode table from accepted items and compares every read.
module hdtb_lookup_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  hdtb_pkg::t_req    i_req,
    input  logic              i_strobe,
    input  hdtb_pkg::t_result i_result,
    output int                o_fail_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [12:0]       code_words [0:65536];
    logic [7:0]        length_counts [hdtb_pkg::HDR_BYTES];
    int unsigned       counts_taken;
    int unsigned       longest;
    int unsigned       cur_len;
    int unsigned       left_at_len;
    int unsigned       next_slot;
    hdtb_pkg::t_result expected_words [$];
    int                failures = 0;

    assign o_fail_count = failures;

    function automatic void restart_spec();
        foreach (length_counts[k]) length_counts[k] = '0;
        counts_taken = 0;
        longest      = 0;
        cur_len      = 1;
        left_at_len  = 0;
        next_slot    = 1;
    endfunction

    // Skip lengths with no codes and load the count of the next used one.
    function automatic void advance_length();
        while (cur_len <= longest && length_counts[cur_len - 1] == 0) cur_len++;
        left_at_len = (cur_len <= longest) ? length_counts[cur_len - 1] : 0;
    endfunction

    function automatic void close_header();
        longest = 0;
        for (int len = hdtb_pkg::HDR_BYTES; len >= 1; len--) begin
            if (longest == 0 && length_counts[len - 1] != 0) longest = len;
        end
        cur_len = 1;
        advance_length();
    endfunction

    function automatic void place_symbol(logic [7:0] sym);
        int unsigned copies;
        if (cur_len > longest || left_at_len == 0) return;
        copies = 1 << (longest - cur_len);
        repeat (copies) begin
            // drop words that would land past the last table entry
            if (next_slot <= (1 << longest)) begin
                code_words[next_slot] = {cur_len[4:0], sym};
                next_slot++;
            end
        end
        left_at_len--;
        if (left_at_len == 0) begin
            cur_len++;
            advance_length();
        end
    endfunction

    function automatic hdtb_pkg::t_result look_up(logic [16:0] idx);
        hdtb_pkg::t_result word;
        word = '0;
        if (idx == 0) begin
            word.read_word = 13'(longest);
            word.in_range  = 1'b1;
        end else if (idx <= (1 << longest)) begin
            word.in_range = 1'b1;
            if (idx < next_slot) word.read_word = code_words[idx];
        end
        return word;
    endfunction

    always @(posedge i_clk) begin : track
        hdtb_pkg::t_result want;
        if (!i_rst_n) begin
            restart_spec();
            expected_words.delete();
        end else begin
            if (i_strobe) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected result: read_word %0h in_range %0b",
                           i_result.read_word, i_result.in_range);
                    failures++;
                end else begin
                    want = expected_words.pop_front();
                    if (i_result.read_word !== want.read_word) begin
                        $error("read_word: expected %0h, got %0h",
                               want.read_word, i_result.read_word);
                        failures++;
                    end
                    if (i_result.in_range !== want.in_range) begin
                        $error("in_range: expected %0b, got %0b",
                               want.in_range, i_result.in_range);
                        failures++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                if (i_req.req_type == hdtb_pkg::REQ_READ) begin
                    expected_words.push_back(look_up(i_req.read_index));
                end else begin
                    if (i_req.start_req) restart_spec();
                    if (counts_taken < hdtb_pkg::HDR_BYTES) begin
                        length_counts[counts_taken] = i_req.data_byte;
                        counts_taken++;
                        if (counts_taken == hdtb_pkg::HDR_BYTES) close_header();
                    end else begin
                        place_symbol(i_req.data_byte);
                    end
                end
            end
        end
        o_pending <= expected_words.size();
    end

endmodule

[bench/huffman_decode_table_builder_tb.sv]
// Testbench top for the Huffman table builder: sends code specifications and reads, gives the verdict.
module huffman_decode_table_builder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET    = 850;
    localparam int WATCHDOG_LIMIT = 200000;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    hdtb_pkg::t_req    i_req   = '0;
    logic              busy;
    logic              o_strobe;
    hdtb_pkg::t_result o_result;
    int                fail_count;
    int                pending;
    int                items_sent  = 0;
    int                idle_cycles = 0;
    int                table_bits  = 0;
    bit                table_done  = 1'b0;
    bit                no_gaps     = 1'b0;

    always #5 i_clk = ~i_clk;

    huffman_decode_table_builder dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    hdtb_lookup_checker lookup_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (i_req),
        .i_strobe     (o_strobe),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int gap_length();
        int roll;
        if (no_gaps) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [16:0] pick_index();
        int top_idx;
        top_idx = 1 << table_bits;
        case ($urandom_range(0, 9))
            7:       return $urandom_range(0, 1) ? 17'(top_idx) : 17'(top_idx + 1);
            8, 9:    return 17'($urandom_range(0, 17'h1FFFF));
            default: return 17'($urandom_range(0, top_idx + 1));
        endcase
    endfunction

    // Called at a falling edge; returns at a falling edge with start not yet driven there.
    task automatic issue(hdtb_pkg::t_req item);
        int gap;
        logic [31:0] noise;
        logic [$bits(hdtb_pkg::t_req)-1:0] junk;
        start <= 1'b1;
        i_req <= item;
        do @(posedge i_clk); while (busy !== 1'b0);
        items_sent++;
        @(negedge i_clk);
        gap = gap_length();
        if (gap > 0) begin
            noise = $urandom;
            junk  = noise[$bits(hdtb_pkg::t_req)-1:0];
            start <= 1'b0;
            i_req <= junk;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_spec_byte(logic first, logic [7:0] value);
        hdtb_pkg::t_req item;
        item.req_type   = hdtb_pkg::REQ_SPEC;
        item.start_req  = first;
        item.data_byte  = value;
        item.read_index = 17'($urandom_range(0, 17'h1FFFF));
        issue(item);
    endtask

    task automatic send_read(logic [16:0] idx, logic restart);
        hdtb_pkg::t_req item;
        item.req_type   = hdtb_pkg::REQ_READ;
        item.start_req  = restart;
        item.data_byte  = 8'($urandom_range(0, 255));
        item.read_index = idx;
        issue(item);
    endtask

    task automatic random_read();
        send_read(pick_index(), 1'($urandom_range(0, 1)));
    endtask

    // Hold start low until every read has been answered.
    task automatic drain_reads();
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    task automatic send_spec(int ml, bit full_size);
        logic [7:0] counts [hdtb_pkg::HDR_BYTES];
        int total;
        int nsend;
        int hdr_len;
        foreach (counts[k]) counts[k] = '0;
        if (full_size) begin
            counts[0] = 8'd1;
            for (int k = 1; k < 15; k++) counts[k] = 8'($urandom_range(0, 1));
            counts[15] = 8'($urandom_range(128, 255));
        end else begin
            for (int k = 0; k < ml - 1; k++)
                counts[k] = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
            counts[ml - 1] = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 255)
                                                            : $urandom_range(1, 8));
        end
        // cut a few headers short; the next restart abandons them
        hdr_len = (!full_size && $urandom_range(0, 9) == 0) ? $urandom_range(1, 15)
                                                            : hdtb_pkg::HDR_BYTES;
        for (int k = 0; k < hdr_len; k++) begin
            send_spec_byte(k == 0, counts[k]);
            if ($urandom_range(0, 7) == 0) random_read();
        end
        if (hdr_len < hdtb_pkg::HDR_BYTES) begin
            table_done = 1'b0;
            return;
        end
        table_done = 1'b1;
        table_bits = ml;
        total = 0;
        foreach (counts[k]) total += counts[k];
        if (full_size) nsend = total - counts[15] + 20;
        else if ($urandom_range(0, 3) == 0) nsend = $urandom_range(0, total + 4);
        else nsend = total + $urandom_range(0, 2);
        if (nsend > 60) nsend = 60;
        for (int k = 0; k < nsend; k++) begin
            send_spec_byte(1'b0, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 5) == 0) random_read();
        end
        repeat (full_size ? $urandom_range(6, 12) : $urandom_range(1, 6)) random_read();
    endtask

    initial begin : stimulus
        int roll;
        int ml;
        int full_done;
        full_done = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reads with an empty table, restart flag on a read
        send_read(17'd0, 1'b1);
        send_read(17'h10000, 1'b0);
        send_read(17'd1, 1'b0);
        // counts without a restart: one code of length 1, one of 2, three of 3
        for (int k = 0; k < hdtb_pkg::HDR_BYTES; k++)
            send_spec_byte(1'b0, (k < 2) ? 8'd1 : (k == 2) ? 8'd3 : 8'd0);
        send_spec_byte(1'b0, 8'hFF);
        send_spec_byte(1'b0, 8'h00);
        send_spec_byte(1'b0, 8'hA5);
        send_spec_byte(1'b0, 8'h5A);
        send_spec_byte(1'b0, 8'h3C);    // table already full: dropped
        send_spec_byte(1'b0, 8'hC3);    // beyond the counts: ignored
        table_bits = 3;
        table_done = 1'b1;
        send_read(17'd0, 1'b0);
        send_read(17'd5, 1'b0);
        send_read(17'd8, 1'b0);
        send_read(17'd9, 1'b0);

        while (items_sent < ITEM_TARGET) begin
            no_gaps = ($urandom_range(0, 4) == 0);
            if ((full_done == 0 && items_sent > 250) || (full_done == 1 && items_sent > 550)) begin
                drain_reads();
                send_spec(16, 1'b1);
                full_done++;
            end else begin
                roll = $urandom_range(0, 19);
                if (roll < 15) begin
                    roll = $urandom_range(0, 9);
                    if (roll < 4) ml = $urandom_range(1, 4);
                    else if (roll < 9) ml = $urandom_range(5, 8);
                    else ml = $urandom_range(9, 12);
                    send_spec(ml, 1'b0);
                end else if (roll < 18 || !table_done) begin
                    repeat ($urandom_range(1, 4)) random_read();
                end else begin
                    repeat ($urandom_range(1, 5))
                        send_spec_byte(1'b0, 8'($urandom_range(0, 255)));
                end
            end
        end

        drain_reads();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[filelist.f]
design/hdtb_pkg.sv
design/hdtb_ram.sv
design/huffman_decode_table_builder.sv
bench/hdtb_lookup_checker.sv
bench/huffman_decode_table_builder_tb.sv
